@@ rtl/core/spa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_pkg
// Shared types and constants of the sparse polynomial arithmetic block.
// ----------------------------------------------------------------------------
package spa_pkg;

    localparam int OPERAND_TERMS = 16;
    localparam int RESULT_TERMS  = 64;
    localparam int OP_IDX_W  = (OPERAND_TERMS > 1) ? $clog2(OPERAND_TERMS) : 1;
    localparam int OP_CNT_W  = $clog2(OPERAND_TERMS + 1);
    localparam int RES_IDX_W = (RESULT_TERMS > 1) ? $clog2(RESULT_TERMS) : 1;
    localparam int RES_CNT_W = $clog2(RESULT_TERMS + 1);

    localparam logic OPER_ADD = 1'b0;
    localparam logic OPER_MUL = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_a;
        logic load_b;
        logic start;
        logic clear;
        logic mul_step;
        logic mul_rd;
        logic mul_mult;
        logic mul_search;
        logic mul_apply;
        logic add_step;
        logic out_rd;
        logic out_show;
    } spa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pairs_done;
        logic search_done;
        logic add_done;
        logic out_done;
    } spa_sts_t;

    // Saturate a 34-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -34'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

@@ rtl/core/spa_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module spa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/spa_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_datapath
// Term stores, product and sum units, result store and output register.
// ----------------------------------------------------------------------------
module spa_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  spa_pkg::spa_cmd_t    cmd,
    output spa_pkg::spa_sts_t    sts,
    input  logic signed [31:0]   coef_in,
    input  logic [7:0]           expon_in,
    output logic signed [31:0]   coef_out,
    output logic [8:0]           expon_out,
    output logic                 result_last,
    output logic                 overflow
);

    localparam int OIW = spa_pkg::OP_IDX_W;
    localparam int OCW = spa_pkg::OP_CNT_W;
    localparam int RIW = spa_pkg::RES_IDX_W;
    localparam int RCW = spa_pkg::RES_CNT_W;

    logic [OCW-1:0] a_count_reg, a_count_next, b_count_reg, b_count_next;
    logic [RCW-1:0] res_count_reg, res_count_next;
    logic [OCW-1:0] i_reg, i_next, j_reg, j_next;
    logic [RCW-1:0] k_reg, k_next;
    logic           ovf_reg, ovf_next;
    logic           hit_reg, hit_next;
    logic [RIW-1:0] hit_idx_reg, hit_idx_next;

    // Operand stores: one RAM per operand holding coefficient and exponent.
    logic           a_we, b_we;
    logic [OIW-1:0] a_raddr, b_raddr;
    logic [39:0]    a_rd, b_rd;

    assign a_we = cmd.load_a && (a_count_reg < OCW'(spa_pkg::OPERAND_TERMS));
    assign b_we = cmd.load_b && (b_count_reg < OCW'(spa_pkg::OPERAND_TERMS));

    spa_ram #(.WIDTH(40), .DEPTH(spa_pkg::OPERAND_TERMS)) u_a_ram (
        .clk  (clk),
        .we   (a_we),
        .waddr(a_count_reg[OIW-1:0]),
        .wdata({coef_in, expon_in}),
        .raddr(a_raddr),
        .rdata(a_rd)
    );

    spa_ram #(.WIDTH(40), .DEPTH(spa_pkg::OPERAND_TERMS)) u_b_ram (
        .clk  (clk),
        .we   (b_we),
        .waddr(b_count_reg[OIW-1:0]),
        .wdata({coef_in, expon_in}),
        .raddr(b_raddr),
        .rdata(b_rd)
    );

    assign a_raddr = i_reg[OIW-1:0];
    assign b_raddr = j_reg[OIW-1:0];

    logic signed [31:0] a_c, b_c;
    logic [7:0]         a_e, b_e;
    assign a_c = a_rd[39:8];
    assign a_e = a_rd[7:0];
    assign b_c = b_rd[39:8];
    assign b_e = b_rd[7:0];

    // Result store: one RAM holding coefficient and exponent.
    logic           r_we;
    logic [RIW-1:0] r_waddr, r_raddr;
    logic [40:0]    r_wdata, r_rd;

    spa_ram #(.WIDTH(41), .DEPTH(spa_pkg::RESULT_TERMS)) u_r_ram (
        .clk  (clk),
        .we   (r_we),
        .waddr(r_waddr),
        .wdata(r_wdata),
        .raddr(r_raddr),
        .rdata(r_rd)
    );

    logic signed [31:0] r_c;
    logic [8:0]         r_e;
    assign r_c = r_rd[40:9];
    assign r_e = r_rd[8:0];

    // Product pipeline: registered 64-bit product, then rounding.
    logic signed [63:0] prod_reg;
    logic [8:0]         pexp_reg;
    logic signed [31:0] pq_reg;
    logic [8:0]         pqe_reg;
    logic [63:0]        mag;
    logic [48:0]        rmag;
    logic signed [49:0] rsig;
    logic signed [31:0] pq_next;

    always_comb
    begin
        mag  = prod_reg[63] ? (64'd0 - prod_reg) : prod_reg;
        rmag = 49'((mag + 64'h8000) >> 16);
        rsig = prod_reg[63] ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
        if (rsig > 50'sd2147483647)
            pq_next = 32'sh7fffffff;
        else if (rsig < -50'sd2147483648)
            pq_next = 32'sh80000000;
        else
            pq_next = rsig[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_mult)
        begin
            prod_reg <= 64'(a_c) * 64'(b_c);
            pexp_reg <= {1'b0, a_e} + {1'b0, b_e};
        end
        if (cmd.mul_search && (k_reg == '0))
        begin
            pq_reg  <= pq_next;
            pqe_reg <= pexp_reg;
        end
    end

    // Add-mode merge decision on the current pair of heads.
    logic a_left, b_left;
    assign a_left = i_reg < a_count_reg;
    assign b_left = j_reg < b_count_reg;

    logic signed [31:0] sum_ab, sum_hit;
    assign sum_ab  = spa_pkg::sat32(34'(a_c) + 34'(b_c));
    assign sum_hit = spa_pkg::sat32(34'(r_c) + 34'(pq_reg));

    logic           push;
    logic [40:0]    push_data;
    logic           add_adv_i, add_adv_j;

    always_comb
    begin
        push      = 1'b0;
        push_data = '0;
        add_adv_i = 1'b0;
        add_adv_j = 1'b0;
        if (cmd.add_step)
        begin
            if (a_left && b_left)
            begin
                if (a_e > b_e)
                begin
                    push = 1'b1;  push_data = {a_c, 1'b0, a_e};  add_adv_i = 1'b1;
                end
                else if (a_e == b_e)
                begin
                    push = (sum_ab != 32'sd0);
                    push_data = {sum_ab, 1'b0, a_e};
                    add_adv_i = 1'b1;  add_adv_j = 1'b1;
                end
                else
                begin
                    push = 1'b1;  push_data = {b_c, 1'b0, b_e};  add_adv_j = 1'b1;
                end
            end
            else if (a_left)
            begin
                push = 1'b1;  push_data = {a_c, 1'b0, a_e};  add_adv_i = 1'b1;
            end
            else if (b_left)
            begin
                push = 1'b1;  push_data = {b_c, 1'b0, b_e};  add_adv_j = 1'b1;
            end
        end
        else if (cmd.mul_apply && !hit_reg)
        begin
            push = 1'b1;  push_data = {pq_reg, pqe_reg};
        end
    end

    logic room;
    assign room = res_count_reg < RCW'(spa_pkg::RESULT_TERMS);

    always_comb
    begin
        r_we    = 1'b0;
        r_waddr = res_count_reg[RIW-1:0];
        r_wdata = push_data;
        if (cmd.mul_apply && hit_reg)
        begin
            r_we    = 1'b1;
            r_waddr = hit_idx_reg;
            r_wdata = {sum_hit, pqe_reg};
        end
        else if (push && room)
        begin
            r_we = 1'b1;
        end
    end

    // Search reads entry k; the read data for entry k-1 is compared.
    // Once a match is found, the matching entry is read so that its
    // coefficient is ready when the sum is written back.
    logic [RCW-1:0] k_prev;
    assign k_prev  = k_reg - RCW'(1);
    assign r_raddr = hit_reg ? hit_idx_reg : k_reg[RIW-1:0];

    logic search_cmp;
    assign search_cmp = cmd.mul_search && (k_reg != '0) && !hit_reg &&
                        (r_e == pqe_reg);

    always_comb
    begin
        a_count_next   = a_count_reg;
        b_count_next   = b_count_reg;
        res_count_next = res_count_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        ovf_next       = ovf_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        if (a_we)
            a_count_next = a_count_reg + OCW'(1);
        if (b_we)
            b_count_next = b_count_reg + OCW'(1);
        if (cmd.start)
        begin
            i_next = '0;  j_next = '0;  res_count_next = '0;  ovf_next = 1'b0;
        end
        if (push && !(cmd.mul_apply && hit_reg))
        begin
            if (room)
                res_count_next = res_count_reg + RCW'(1);
            else
                ovf_next = 1'b1;
        end
        if (add_adv_i)
            i_next = i_reg + OCW'(1);
        if (add_adv_j)
            j_next = j_reg + OCW'(1);
        if (cmd.mul_rd)
        begin
            k_next = '0;  hit_next = 1'b0;
        end
        if (cmd.mul_search)
        begin
            k_next = k_reg + RCW'(1);
            if (search_cmp)
            begin
                hit_next     = 1'b1;
                hit_idx_next = k_prev[RIW-1:0];
            end
        end
        if (cmd.mul_step)
        begin
            if (j_reg + OCW'(1) >= b_count_reg)
            begin
                j_next = '0;  i_next = i_reg + OCW'(1);
            end
            else
                j_next = j_reg + OCW'(1);
        end
        if (cmd.out_rd)
            k_next = k_reg + RCW'(1);
        if (cmd.start && !cmd.mul_rd)
            k_next = '0;
        if (cmd.clear)
        begin
            a_count_next = '0;  b_count_next = '0;  k_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_count_reg   <= '0;
            b_count_reg   <= '0;
            res_count_reg <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            ovf_reg       <= 1'b0;
            hit_reg       <= 1'b0;
            hit_idx_reg   <= '0;
        end
        else
        begin
            a_count_reg   <= a_count_next;
            b_count_reg   <= b_count_next;
            res_count_reg <= res_count_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            ovf_reg       <= ovf_next;
            hit_reg       <= hit_next;
            hit_idx_reg   <= hit_idx_next;
        end
    end

    // Output register, loaded from the result RAM read of the previous cycle.
    logic [RCW-1:0] out_idx_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.out_rd)
            out_idx_reg <= k_reg;
        if (cmd.out_show)
        begin
            if (res_count_reg == '0)
            begin
                coef_out  <= '0;
                expon_out <= '0;
            end
            else
            begin
                coef_out  <= r_c;
                expon_out <= r_e;
            end
            result_last <= (res_count_reg == '0) ||
                           (out_idx_reg + RCW'(1) >= res_count_reg);
            overflow    <= ovf_reg;
        end
    end

    assign sts.pairs_done  = (i_reg >= a_count_reg) || (b_count_reg == '0);
    assign sts.search_done = hit_reg || (k_reg > res_count_reg) ||
                             (k_reg == res_count_reg && k_reg == '0);
    assign sts.add_done    = !a_left && !b_left;
    // The entry being read now is the final one to stream out.
    assign sts.out_done    = (k_reg + RCW'(1) >= res_count_reg);

endmodule

@@ rtl/core/spa_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_ctrl
// Sequencer: loads, multiply and merge passes, and result streaming.
// ----------------------------------------------------------------------------
module spa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid,
    output logic              ready,
    input  logic              mode,
    input  logic              last,
    input  logic              operation,
    output logic              out_valid,
    input  logic              out_ready,
    input  spa_pkg::spa_sts_t sts,
    output spa_pkg::spa_cmd_t cmd
);

    typedef enum logic [9:0] {
        ST_LOAD   = 10'b0000000001,
        ST_MRD    = 10'b0000000010,
        ST_MMUL   = 10'b0000000100,
        ST_MRND   = 10'b0000001000,
        ST_MSRCH  = 10'b0000010000,
        ST_MAPPLY = 10'b0000100000,
        ST_ARD    = 10'b0001000000,
        ST_ASTEP  = 10'b0010000000,
        ST_ORD    = 10'b0100000000,
        ST_OUT    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   oshow_reg, oshow_next;
    logic   fin_reg, fin_next;

    assign ready     = (state_reg == ST_LOAD);
    assign out_valid = out_valid_reg;

    logic acc;
    assign acc = valid && ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg;
        oshow_next     = 1'b0;
        fin_next       = fin_reg;
        cmd.out_show   = oshow_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (oshow_reg)
            out_valid_next = 1'b1;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (acc)
                begin
                    cmd.load_a = !mode;
                    cmd.load_b = mode;
                    if (mode && last)
                    begin
                        cmd.start  = 1'b1;
                        state_next = (operation == spa_pkg::OPER_MUL) ? ST_MRD : ST_ARD;
                    end
                end
            end
            ST_MRD:
            begin
                if (sts.pairs_done)
                begin
                    // Rewind the entry index so streaming starts at entry 0.
                    cmd.mul_rd = 1'b1;
                    state_next = ST_ORD;
                end
                else
                    state_next = ST_MMUL;
            end
            ST_MMUL:
            begin
                cmd.mul_mult = 1'b1;
                cmd.mul_rd   = 1'b1;
                state_next   = ST_MRND;
            end
            ST_MRND:
            begin
                cmd.mul_search = 1'b1;
                state_next     = ST_MSRCH;
            end
            ST_MSRCH:
            begin
                if (sts.search_done)
                    state_next = ST_MAPPLY;
                else
                    cmd.mul_search = 1'b1;
            end
            ST_MAPPLY:
            begin
                cmd.mul_apply = 1'b1;
                cmd.mul_step  = 1'b1;
                state_next    = ST_MRD;
            end
            ST_ARD:
            begin
                state_next = sts.add_done ? ST_ORD : ST_ASTEP;
            end
            ST_ASTEP:
            begin
                cmd.add_step = 1'b1;
                state_next   = ST_ARD;
            end
            ST_ORD:
            begin
                if (!out_valid_next && !oshow_reg)
                begin
                    cmd.out_rd = 1'b1;
                    oshow_next = 1'b1;
                    fin_next   = sts.out_done || 1'b0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (fin_reg)
                begin
                    if (!oshow_reg && !out_valid_next)
                    begin
                        cmd.clear  = 1'b1;
                        fin_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                end
                else if (!oshow_reg)
                    state_next = ST_ORD;
            end
            default:
                state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            out_valid_reg <= 1'b0;
            oshow_reg     <= 1'b0;
            fin_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            oshow_reg     <= oshow_next;
            fin_reg       <= fin_next;
        end
    end

    // A load is never taken while results are being delivered.
    assert property (@(posedge clk) disable iff (!rst_n) out_valid_reg |-> !ready)
        else $error("input accepted while result pending");
    // The output register is loaded only after a read was issued.
    assert property (@(posedge clk) disable iff (!rst_n) oshow_reg |-> $past(cmd.out_rd))
        else $error("output shown without read");
    // A search always follows a multiply issue.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_mult |=> state_reg == ST_MRND)
        else $error("multiply sequence broken");

endmodule

@@ rtl/core/sparse_polynomial_arith.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_polynomial_arith
// Sparse polynomial multiply and merge-add with Q16.16 coefficients.
// ----------------------------------------------------------------------------
// Operand terms load one per cycle. The last B term starts the computation,
// during which no input transfer is taken. For each term pair, multiply
// searches the result store one entry per cycle through its single read
// port, stopping at a matching exponent. Add alternates a read state and a
// merge step. Each result term then streams out through the output register,
// the next one read only after the previous one is taken.
module sparse_polynomial_arith (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               mode,
    input  logic signed [31:0] coef_in,
    input  logic [7:0]         expon_in,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] coef_out,
    output logic [8:0]         expon_out,
    output logic               result_last,
    output logic               overflow
);

    logic operation_reg;
    spa_pkg::spa_cmd_t cmd;
    spa_pkg::spa_sts_t sts;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {31'd0, operation_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            operation_reg <= spa_pkg::OPER_MUL;
        else if (psel && penable && pwrite && paddr == 2'd0)
            operation_reg <= pwdata[0];
    end

    spa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid    (in_valid),
        .ready    (in_ready),
        .mode     (mode),
        .last     (last),
        .operation(operation_reg),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    spa_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .coef_in    (coef_in),
        .expon_in   (expon_in),
        .coef_out   (coef_out),
        .expon_out  (expon_out),
        .result_last(result_last),
        .overflow   (overflow)
    );

endmodule
